@@ src/bmmd_pkg.sv @@
// Package for the banked memory map decoder: item types, action and source codes,
// decode result structs. No dependencies.
`default_nettype none

package bmmd_pkg;

   // action codes
   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_PEEK   = 3'd1;
   localparam logic [2:0] ACT_WRITE  = 3'd2;
   localparam logic [2:0] ACT_LD_BAS = 3'd3;
   localparam logic [2:0] ACT_LD_KER = 3'd4;
   localparam logic [2:0] ACT_LD_CHR = 3'd5;

   // source codes
   localparam logic [2:0] SRC_RAM    = 3'd0;
   localparam logic [2:0] SRC_BASIC  = 3'd1;
   localparam logic [2:0] SRC_KERNAL = 3'd2;
   localparam logic [2:0] SRC_CHAR   = 3'd3;
   localparam logic [2:0] SRC_IO     = 3'd4;
   localparam logic [2:0] SRC_VIDEO  = 3'd5;
   localparam logic [2:0] SRC_NONE   = 3'd6;

   // video request codes
   localparam logic [1:0] VREQ_NONE  = 2'd0;
   localparam logic [1:0] VREQ_READ  = 2'd1;
   localparam logic [1:0] VREQ_WRITE = 2'd2;

   // address map
   localparam logic [2:0]  BASIC_PAGE    = 3'b101;   // A000-BFFF
   localparam logic [2:0]  KERNAL_PAGE   = 3'b111;   // E000-FFFF
   localparam logic [3:0]  D_PAGE        = 4'hD;     // D000-DFFF
   localparam logic [11:0] VIDEO_WR_LAST = 12'h02E;  // video registers on write
   localparam logic [15:0] BANK_ADDR     = 16'h0001;

   localparam logic [7:0] BYTE0_RESET = 8'h2F;
   localparam logic [7:0] BYTE1_RESET = 8'h37;

   localparam int RAM_AW  = 16;
   localparam int ROM_AW  = 13;
   localparam int CHR_AW  = 12;
   localparam int IO_AW   = 12;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] source;
      logic [1:0] video_request;
      logic [9:0] video_offset;
      logic [7:0] video_data;
      logic       rom_write_hit;
   } rsp_type;

   // which store supplies read_data
   typedef enum logic [2:0] {
      RD_ZERO,
      RD_RAM,
      RD_LOW,
      RD_BASIC,
      RD_KERNAL,
      RD_CHAR,
      RD_IO
   } rd_sel_type;

   typedef struct packed {
      logic ram;
      logic basic;
      logic kernal;
      logic chr;
      logic io;
      logic low;
   } we_type;

   typedef struct packed {
      rd_sel_type sel;
      rsp_type    rsp;
      we_type     we;
   } dec_type;

endpackage

`default_nettype wire

@@ src/banked_memory_map_decoder_unit.sv @@
// Banked memory map decoder top level: five single-port stores, decode, output register.
// Path: an accepted item fills the store read and stage-1 registers, then the output register.
// Throughput: one item per cycle unless rsp_ready stalls the output; each store sees one read or one write per item.
// Reset: control cleared, RAM bytes 0/1 held in registers preset to 2F/37 (bank mode 7).
// No clearing pass; other store contents are undefined until written.
// Depends on bmmd_pkg and bmmd_decode.
`default_nettype none

module banked_memory_map_decoder_unit (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   output var logic              req_ready,
   input  var bmmd_pkg::req_type req_item,
   output var logic              rsp_valid,
   input  var logic              rsp_ready,
   output var bmmd_pkg::rsp_type rsp_item
);
   import bmmd_pkg::*;

   logic [7:0] ram_mem    [2**RAM_AW];
   logic [7:0] basic_mem  [2**ROM_AW];
   logic [7:0] kernal_mem [2**ROM_AW];
   logic [7:0] char_mem   [2**CHR_AW];
   logic [7:0] io_mem     [2**IO_AW];

   logic [7:0] ram_rd_ff, basic_rd_ff, kernal_rd_ff, char_rd_ff, io_rd_ff;

   logic [7:0] byte0_ff, byte0_in, byte1_ff, byte1_in;
   logic       s1_valid_ff, s1_valid_in;
   rd_sel_type s1_sel_ff;
   rsp_type    s1_rsp_ff;
   logic [7:0] s1_low_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   dec_type    dec;
   logic       req_accept, s1_adv;

   bmmd_decode u_decode (
      .item (req_item),
      .bank (byte1_ff[2:0]),
      .dec  (dec)
   );

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   // stores: write on accept when targeted, otherwise read at the item address
   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (dec.we.ram) begin
            ram_mem[req_item.address[RAM_AW-1:0]] <= req_item.write_data;
         end else begin
            ram_rd_ff <= ram_mem[req_item.address[RAM_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (dec.we.basic) begin
            basic_mem[req_item.address[ROM_AW-1:0]] <= req_item.write_data;
         end else begin
            basic_rd_ff <= basic_mem[req_item.address[ROM_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (dec.we.kernal) begin
            kernal_mem[req_item.address[ROM_AW-1:0]] <= req_item.write_data;
         end else begin
            kernal_rd_ff <= kernal_mem[req_item.address[ROM_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (dec.we.chr) begin
            char_mem[req_item.address[CHR_AW-1:0]] <= req_item.write_data;
         end else begin
            char_rd_ff <= char_mem[req_item.address[CHR_AW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         if (dec.we.io) begin
            io_mem[req_item.address[IO_AW-1:0]] <= req_item.write_data;
         end else begin
            io_rd_ff <= io_mem[req_item.address[IO_AW-1:0]];
         end
      end
   end

   // bytes 0 and 1 shadow; byte 1 low bits are the bank mode
   always_comb begin
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      if (req_accept && dec.we.low) begin
         if (req_item.address[0]) begin
            byte1_in = req_item.write_data;
         end else begin
            byte0_in = req_item.write_data;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in = s1_rsp_ff;
      case (s1_sel_ff)
         RD_RAM:    rsp_in.read_data = ram_rd_ff;
         RD_LOW:    rsp_in.read_data = s1_low_ff;
         RD_BASIC:  rsp_in.read_data = basic_rd_ff;
         RD_KERNAL: rsp_in.read_data = kernal_rd_ff;
         RD_CHAR:   rsp_in.read_data = char_rd_ff;
         RD_IO:     rsp_in.read_data = io_rd_ff;
         default:   rsp_in.read_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte0_ff     <= BYTE0_RESET;
         byte1_ff     <= BYTE1_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte0_ff     <= byte0_in;
         byte1_ff     <= byte1_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sel_ff <= dec.sel;
         s1_rsp_ff <= dec.rsp;
         s1_low_ff <= req_item.address[0] ? byte1_ff : byte0_ff;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_bank_update: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_item.action == ACT_WRITE && req_item.address == BANK_ADDR
      |=> byte1_ff == $past(req_item.write_data))
      else $error("bank byte not updated by write to byte 1");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("pending item dropped from store stage");

   a_video_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.source == SRC_VIDEO |-> rsp_ff.video_request != VREQ_NONE)
      else $error("video source without video request");

   a_none_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.source == SRC_NONE
      |-> rsp_ff.read_data == '0 && rsp_ff.video_request == VREQ_NONE)
      else $error("load or unused action produced data");

   a_rom_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rom_write_hit |-> rsp_ff.source == SRC_RAM)
      else $error("ROM window hit outside a plain RAM write");
`endif

endmodule

`default_nettype wire

@@ src/bmmd_decode.sv @@
// Address and banking decode for one bus item: picks the read store, the write
// targets and the response fields. Depends on bmmd_pkg.
`default_nettype none

module bmmd_decode (
   input  var bmmd_pkg::req_type item,
   input  var logic [2:0]        bank,
   output var bmmd_pkg::dec_type dec
);
   import bmmd_pkg::*;

   logic basic_on, kernal_on, io_on, char_on;
   logic in_basic, in_kernal, in_d, in_video_rd, in_video_wr, in_io_wr;

   assign basic_on  = bank[0];
   assign kernal_on = bank[1];
   assign io_on     = bank[2];
   assign char_on   = (bank == 3'd3);

   assign in_basic    = (item.address[15:13] == BASIC_PAGE);
   assign in_kernal   = (item.address[15:13] == KERNAL_PAGE);
   assign in_d        = (item.address[15:12] == D_PAGE);
   assign in_video_rd = (item.address[11:10] == 2'b00);
   assign in_video_wr = (item.address[11:0] <= VIDEO_WR_LAST);
   assign in_io_wr    = in_video_rd && !in_video_wr;

   always_comb begin
      dec = '0;
      dec.sel = RD_ZERO;
      dec.rsp.source = SRC_NONE;
      case (item.action)
         ACT_READ, ACT_PEEK: begin
            dec.rsp.source = SRC_RAM;
            dec.sel = RD_RAM;
            if (in_basic && basic_on) begin
               dec.rsp.source = SRC_BASIC;
               dec.sel = RD_BASIC;
            end else if (in_kernal && kernal_on) begin
               dec.rsp.source = SRC_KERNAL;
               dec.sel = RD_KERNAL;
            end else if (in_d && io_on) begin
               if (item.action == ACT_PEEK) begin
                  dec.rsp.source = SRC_IO;
                  dec.sel = RD_IO;
               end else if (in_video_rd) begin
                  dec.rsp.source = SRC_VIDEO;
                  dec.sel = RD_ZERO;
                  dec.rsp.video_request = VREQ_READ;
                  dec.rsp.video_offset = item.address[9:0];
               end
            end else if (in_d && char_on) begin
               dec.rsp.source = SRC_CHAR;
               dec.sel = RD_CHAR;
            end
            // bytes 0 and 1 live in registers
            if (dec.sel == RD_RAM && item.address[15:1] == '0) begin
               dec.sel = RD_LOW;
            end
         end
         ACT_WRITE: begin
            dec.rsp.source = SRC_RAM;
            dec.rsp.rom_write_hit = (in_basic && basic_on) || (in_kernal && kernal_on);
            dec.we.ram = 1'b1;
            dec.we.low = (item.address[15:1] == '0);
            if (in_d && io_on) begin
               if (in_video_wr) begin
                  dec.rsp.source = SRC_VIDEO;
                  dec.rsp.video_request = VREQ_WRITE;
                  dec.rsp.video_offset = item.address[9:0];
                  dec.rsp.video_data = item.write_data;
               end else if (in_io_wr) begin
                  dec.rsp.source = SRC_IO;
                  dec.we.io = 1'b1;
               end
            end else if (in_d && char_on) begin
               dec.rsp.source = SRC_CHAR;
               dec.we.chr = 1'b1;
            end
         end
         ACT_LD_BAS: dec.we.basic = 1'b1;
         ACT_LD_KER: dec.we.kernal = 1'b1;
         ACT_LD_CHR: dec.we.chr = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

@@ tb/sv/tb_banked_memory_map_decoder_unit.sv @@
// Self-checking testbench for banked_memory_map_decoder_unit: directed table, then random
// bus accesses checked against a shadow copy of RAM, ROMs, char and IO stores.
// Depends on bmmd_pkg and the decoder RTL.
module tb_banked_memory_map_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import bmmd_pkg::*;

   // action codes the block ignores
   localparam logic [2:0] ACT_SPARE6 = 3'd6;
   localparam logic [2:0] ACT_SPARE7 = 3'd7;

   localparam int RANDOM_ITEMS = 1850;
   localparam int QUIET_FROM   = 1600;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 8;

   localparam rsp_type NO_ACCESS_RSP = {8'h00, SRC_NONE, VREQ_NONE, 10'h000, 8'h00, 1'b0};

   typedef struct packed {
      req_type req;
      logic    checked;
      rsp_type rsp;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // shadow stores with written flags
   logic [7:0] ram_img    [0:65535];
   bit         ram_wr     [0:65535];
   logic [7:0] basic_img  [0:8191];
   bit         basic_wr   [0:8191];
   logic [7:0] kernal_img [0:8191];
   bit         kernal_wr  [0:8191];
   logic [7:0] char_img   [0:4095];
   bit         char_wr    [0:4095];
   logic [7:0] io_img     [0:4095];
   bit         io_wr      [0:4095];
   logic [2:0] bank_mode = 3'd7;

   directed_row_type directed_rows [$];
   rsp_type          expected_q [$];
   rsp_type          want;
   int               errors     = 0;
   int               cycles     = 0;
   int               gap_pct    = 0;
   int               ready_hold = 0;
   bit               quiet      = 1'b0;

   always #2 clock = ~clock;

   banked_memory_map_decoder_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   function automatic logic [2:0] read_source(logic peek, logic [15:0] a);
      logic in_d;
      in_d = (a[15:12] == 4'hD);
      if (bank_mode == 3'd0) return SRC_RAM;
      if (a[15:13] == 3'b101 && bank_mode[0]) return SRC_BASIC;
      if (a[15:13] == 3'b111 && bank_mode[1]) return SRC_KERNAL;
      if (in_d && bank_mode[2]) begin
         if (peek) return SRC_IO;
         return (a <= 16'hD3FF) ? SRC_VIDEO : SRC_RAM;
      end
      if (in_d && bank_mode == 3'd3) return SRC_CHAR;
      return SRC_RAM;
   endfunction

   function automatic bit entry_known(logic [2:0] src, logic [15:0] a);
      case (src)
         SRC_RAM:    return ram_wr[a];
         SRC_BASIC:  return basic_wr[a[12:0]];
         SRC_KERNAL: return kernal_wr[a[12:0]];
         SRC_CHAR:   return char_wr[a[11:0]];
         SRC_IO:     return io_wr[a[11:0]];
         default:    return 1'b1;
      endcase
   endfunction

   // Decode one access against the shadow stores and apply its writes.
   function automatic rsp_type decode_access(req_type it);
      rsp_type     r;
      logic [15:0] a;
      logic [7:0]  d;
      logic        in_d;
      a = it.address;
      d = it.write_data;
      in_d = (a[15:12] == 4'hD);
      r = NO_ACCESS_RSP;
      case (it.action)
         ACT_READ, ACT_PEEK: begin
            r.source = read_source(it.action == ACT_PEEK, a);
            case (r.source)
               SRC_BASIC:  r.read_data = basic_img[a[12:0]];
               SRC_KERNAL: r.read_data = kernal_img[a[12:0]];
               SRC_CHAR:   r.read_data = char_img[a[11:0]];
               SRC_IO:     r.read_data = io_img[a[11:0]];
               SRC_VIDEO: begin
                  r.video_request = VREQ_READ;
                  r.video_offset  = a[9:0];
               end
               default:    r.read_data = ram_img[a];
            endcase
         end
         ACT_WRITE: begin
            r.source = SRC_RAM;
            r.rom_write_hit = (a[15:13] == 3'b101 && bank_mode[0]) ||
                              (a[15:13] == 3'b111 && bank_mode[1]);
            if (in_d && bank_mode[2]) begin
               if (a <= 16'hD02E) begin
                  r.source        = SRC_VIDEO;
                  r.video_request = VREQ_WRITE;
                  r.video_offset  = a[9:0];
                  r.video_data    = d;
               end else if (a <= 16'hD3FF) begin
                  r.source = SRC_IO;
                  io_img[a[11:0]] = d;
                  io_wr[a[11:0]]  = 1'b1;
               end
            end else if (in_d && bank_mode == 3'd3) begin
               r.source = SRC_CHAR;
               char_img[a[11:0]] = d;
               char_wr[a[11:0]]  = 1'b1;
            end
            ram_img[a] = d;
            ram_wr[a]  = 1'b1;
            // decode above used the old mode
            if (a == 16'h0001) bank_mode = d[2:0];
         end
         ACT_LD_BAS: begin
            basic_img[a[12:0]] = d;
            basic_wr[a[12:0]]  = 1'b1;
         end
         ACT_LD_KER: begin
            kernal_img[a[12:0]] = d;
            kernal_wr[a[12:0]]  = 1'b1;
         end
         ACT_LD_CHR: begin
            char_img[a[11:0]] = d;
            char_wr[a[11:0]]  = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Cluster addresses near window edges so reads land on bytes written before.
   function automatic logic [15:0] pick_address();
      logic [15:0] base;
      case ($urandom_range(0, 11))
         0:       base = 16'h0000;
         1:       base = 16'h0400;
         2:       base = 16'hA000;
         3:       base = 16'hBFC0;
         4:       base = 16'hC000;
         5:       base = 16'hD000;
         6:       base = 16'hD3C0;
         7:       base = 16'hDFC0;
         8:       base = 16'hE000;
         9:       base = 16'hFFC0;
         default: return 16'($urandom);
      endcase
      return base + 16'($urandom_range(0, 63));
   endfunction

   function automatic req_type random_access();
      req_type    it;
      logic [2:0] src;
      int         pick;
      pick = $urandom_range(0, 99);
      it.address    = pick_address();
      it.write_data = 8'($urandom);
      if (pick < 40) begin
         it.action = ($urandom_range(0, 9) < 7) ? ACT_READ : ACT_PEEK;
      end else if (pick < 70) begin
         it.action = ACT_WRITE;
      end else if (pick < 85) begin
         case ($urandom_range(0, 2))
            0:       it.action = ACT_LD_BAS;
            1:       it.action = ACT_LD_KER;
            default: it.action = ACT_LD_CHR;
         endcase
      end else if (pick < 94) begin
         it.action  = ACT_WRITE;
         it.address = 16'h0001;
      end else if (pick < 97) begin
         it.action = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
      end else begin
         it.action  = ACT_WRITE;
         it.address = 16'($urandom);
      end
      if (it.action == ACT_READ || it.action == ACT_PEEK) begin
         src = read_source(it.action == ACT_PEEK, it.address);
         // fill a byte never written rather than read it
         if (!entry_known(src, it.address)) begin
            case (src)
               SRC_BASIC:  it.action = ACT_LD_BAS;
               SRC_KERNAL: it.action = ACT_LD_KER;
               SRC_CHAR:   it.action = ACT_LD_CHR;
               default:    it.action = ACT_WRITE;
            endcase
         end
      end
      return it;
   endfunction

   function automatic void add_row(req_type q, logic checked, rsp_type r);
      directed_rows.push_back({q, checked, r});
   endfunction

   task automatic send_item(input req_type it, input logic checked, input rsp_type typed);
      rsp_type pred;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pred = decode_access(it);
      expected_q.push_back(checked ? typed : pred);
   endtask

   function automatic void check_field(string name, logic [9:0] exp_val, logic [9:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_val, got_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t ns: result expected none, got %p", $time, rsp_item);
            errors++;
         end else begin
            want = expected_q.pop_front();
            check_field("read_data", 10'(want.read_data), 10'(rsp_item.read_data));
            check_field("source", 10'(want.source), 10'(rsp_item.source));
            check_field("video_request", 10'(want.video_request),
                        10'(rsp_item.video_request));
            check_field("video_offset", want.video_offset, rsp_item.video_offset);
            check_field("video_data", 10'(want.video_data), 10'(rsp_item.video_data));
            check_field("rom_write_hit", 10'(want.rom_write_hit),
                        10'(rsp_item.rom_write_hit));
         end
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) != 0) begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 60);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 18);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_type it;
      int      n;
      ram_img[0] = 8'h2F;
      ram_img[1] = 8'h37;
      ram_wr[0]  = 1'b1;
      ram_wr[1]  = 1'b1;

      // mode 7 after reset: BASIC, KERNAL and IO visible
      add_row({ACT_READ,   16'h0000, 8'h00}, 1'b1, {8'h2F, SRC_RAM, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_PEEK,   16'h0001, 8'h00}, 1'b1, {8'h37, SRC_RAM, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_LD_BAS, 16'h0000, 8'hFF}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_LD_BAS, 16'hFFFF, 8'h00}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_LD_KER, 16'h2000, 8'hA5}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_LD_KER, 16'h1FFF, 8'h5A}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_LD_CHR, 16'hF000, 8'hC3}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_LD_CHR, 16'h0FFF, 8'h3C}, 1'b1, NO_ACCESS_RSP);
      add_row({ACT_READ,   16'hA000, 8'h00}, 1'b1, {8'hFF, SRC_BASIC, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_READ,   16'hBFFF, 8'h00}, 1'b1, {8'h00, SRC_BASIC, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_READ,   16'hE000, 8'h00}, 1'b1, {8'hA5, SRC_KERNAL, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_PEEK,   16'hFFFF, 8'h00}, 1'b1, {8'h5A, SRC_KERNAL, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_READ,   16'hD000, 8'h00}, 1'b1, {8'h00, SRC_VIDEO, VREQ_READ, 10'h0, 8'h0, 1'b0});
      add_row({ACT_READ,   16'hD3FF, 8'h00}, 1'b1, {8'h00, SRC_VIDEO, VREQ_READ, 10'h3FF, 8'h0, 1'b0});
      add_row({ACT_WRITE,  16'hD02E, 8'h81}, 1'b1, {8'h00, SRC_VIDEO, VREQ_WRITE, 10'h2E, 8'h81, 1'b0});
      add_row({ACT_WRITE,  16'hD02F, 8'h7E}, 1'b1, {8'h00, SRC_IO, VREQ_NONE, 10'h0, 8'h0, 1'b0});
      add_row({ACT_PEEK,   16'hD02F, 8'h00}, 1'b0, '0);
      add_row({ACT_WRITE,  16'hA000, 8'h11}, 1'b1, {8'h00, SRC_RAM, VREQ_NONE, 10'h0, 8'h0, 1'b1});
      add_row({ACT_WRITE,  16'hFFFF, 8'hEE}, 1'b1, {8'h00, SRC_RAM, VREQ_NONE, 10'h0, 8'h0, 1'b1});
      add_row({ACT_WRITE,  16'hD400, 8'h42}, 1'b0, '0);
      add_row({ACT_READ,   16'hD400, 8'h00}, 1'b0, '0);
      add_row({ACT_SPARE6, 16'hFFFF, 8'hFF}, 1'b1, NO_ACCESS_RSP);
      // character mode, then all RAM, then back to mode 7
      add_row({ACT_WRITE,  16'h0001, 8'h03}, 1'b0, '0);
      add_row({ACT_WRITE,  16'hD000, 8'h99}, 1'b0, '0);
      add_row({ACT_READ,   16'hD000, 8'h00}, 1'b0, '0);
      add_row({ACT_WRITE,  16'h0001, 8'h00}, 1'b0, '0);
      add_row({ACT_READ,   16'hA000, 8'h00}, 1'b0, '0);
      add_row({ACT_WRITE,  16'h0001, 8'hFF}, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].checked, directed_rows[i].rsp);

      // hold off until the directed results are all back
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n % 150 == 0) gap_pct = $urandom_range(0, 3) * 10;
         if (n >= QUIET_FROM) begin
            quiet   = 1'b1;
            gap_pct = 0;
         end
         it = random_access();
         send_item(it, 1'b0, '0);
         if (it.action != ACT_SPARE6 && it.action != ACT_SPARE7) begin
            n++;
            if (n == RANDOM_ITEMS / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (expected_q.size() != 0);
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
